### rtl/core/onrq_pkg.sv
// shared types and constants for the overwrite-newest ring queue
`timescale 1ns / 1ps

package onrq_pkg;

  localparam int MODE_BITS  = 2;
  localparam int FIELD_BITS = 32;
  localparam int OCC_BITS   = 4;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  // per-cell control, driven by the queue controller
  typedef struct packed {
    logic shift;
    logic write;
  } cell_ctrl_t;

endpackage

### rtl/core/onrq_req_if.sv
// request channel: queue operation and entry to store
`timescale 1ns / 1ps

interface onrq_req_if;
  logic                             valid;
  logic                             ready;
  logic [onrq_pkg::MODE_BITS-1:0]   mode;
  logic [onrq_pkg::FIELD_BITS-1:0]  entry_data;

  modport source (output valid, output mode, output entry_data, input ready);
  modport sink   (input valid, input mode, input entry_data, output ready);
endinterface

### rtl/core/onrq_rsp_if.sv
// response channel: popped entry, overwrite flag and occupancy
`timescale 1ns / 1ps

interface onrq_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             popped_valid;
  logic [onrq_pkg::FIELD_BITS-1:0]  popped_data;
  logic                             overwrote_newest;
  logic [onrq_pkg::OCC_BITS-1:0]    occupancy;

  modport source (output valid, output popped_valid, output popped_data,
                  output overwrote_newest, output occupancy, input ready);
  modport sink   (input valid, input popped_valid, input popped_data,
                  input overwrote_newest, input occupancy, output ready);
endinterface

### rtl/core/overwrite_newest_ring_queue.sv
// top level of the overwrite-newest queue: controller, cell chain, response register
`timescale 1ns / 1ps

// usage
// - req channel carries mode (push, pop, clear to newest) and entry_data;
//   rsp channel returns popped_valid, popped_data, overwrote_newest and
//   occupancy, exactly one response per request transfer
// - holds up to DEPTH-1 entries in a chain of cells, oldest in cell 0;
//   a pop takes cell 0 and every cell below the top loads from its upper neighbor
// - a push into a full queue replaces the newest entry and flags it
// - clear keeps only the newest entry, taken from a shadow register
//   of the last pushed value
// - response valid in the cycle after the request transfer
// - throughput: one request per cycle while rsp.ready is high, set by the single
//   response register; every operation updates the chain and count at its transfer
// - receiver stall: req.ready follows rsp.ready while a response waits,
//   so the queue state never runs ahead of the responses
// - reset clears the count and the response valid; cell contents are
//   left as they are and are never read before a push writes them

module overwrite_newest_ring_queue #(
  parameter int DEPTH      = 16,
  parameter int ENTRY_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  onrq_req_if.sink          req,
  onrq_rsp_if.source        rsp
);

  localparam int CW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CELLS = DEPTH - 1;

  // occupancy count, 0 to DEPTH-1
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  // copy of the newest entry for clear
  logic [ENTRY_BITS-1:0] newest;

  logic [ENTRY_BITS-1:0] cell_data [CELLS];
  logic [ENTRY_BITS-1:0] entry_in;
  logic [ENTRY_BITS-1:0] cell_wdata;

  logic                  accept;
  logic                  full;
  onrq_pkg::mode_t       op;

  // chain control decoded per operation
  logic                  do_shift;
  logic                  do_write;
  logic [CW-1:0]         wr_idx;

  // response fields for this transfer
  logic                  pv;
  logic [onrq_pkg::FIELD_BITS-1:0] pd;
  logic                  ow;

  assign accept    = req.valid && req.ready;
  assign req.ready = !rsp.valid || rsp.ready;
  assign op        = onrq_pkg::mode_t'(req.mode);
  assign full      = (count == CW'(DEPTH - 1));
  assign entry_in  = ENTRY_BITS'(req.entry_data);

  // clear reloads cell 0 from the shadow of the newest entry
  assign cell_wdata = (op == onrq_pkg::MODE_CLEAR) ? newest : entry_in;

  always_comb begin
    count_next = count;
    do_shift   = 1'b0;
    do_write   = 1'b0;
    wr_idx     = '0;
    pv         = 1'b0;
    pd         = '0;
    ow         = 1'b0;
    case (op)
      onrq_pkg::MODE_PUSH: begin
        do_write = 1'b1;
        if (!full) begin
          wr_idx     = count;
          count_next = count + CW'(1);
        end else begin
          // full: overwrite the newest entry in place
          wr_idx = count - CW'(1);
          ow     = 1'b1;
        end
      end
      onrq_pkg::MODE_POP: begin
        if (count != '0) begin
          pv         = 1'b1;
          pd         = onrq_pkg::FIELD_BITS'(cell_data[0]);
          do_shift   = 1'b1;
          count_next = count - CW'(1);
        end
      end
      onrq_pkg::MODE_CLEAR: begin
        if (count > CW'(1)) begin
          do_write   = 1'b1;
          wr_idx     = '0;
          count_next = CW'(1);
        end
      end
      default: begin
        // unused code: no change
      end
    endcase
  end

  // cell chain
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    onrq_pkg::cell_ctrl_t  ctrl;
    logic [ENTRY_BITS-1:0] upper;

    assign ctrl.shift = accept && do_shift;
    assign ctrl.write = accept && do_write && (wr_idx == CW'(i));

    if (i == CELLS - 1) begin : g_top
      assign upper = cell_data[i];
    end else begin : g_mid
      assign upper = cell_data[i + 1];
    end

    onrq_cell #(
      .ENTRY_BITS (ENTRY_BITS)
    ) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .upper (upper),
      .wdata (cell_wdata),
      .data  (cell_data[i])
    );
  end

  // count and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept && op == onrq_pkg::MODE_PUSH) begin
      newest <= entry_in;
    end
    if (accept) begin
      rsp.popped_valid     <= pv;
      rsp.popped_data      <= pd;
      rsp.overwrote_newest <= ow;
      rsp.occupancy        <= onrq_pkg::OCC_BITS'(count_next);
    end
  end

endmodule

### rtl/core/onrq_cell.sv
// one storage cell of the queue chain: load, take from upper neighbor, or hold
`timescale 1ns / 1ps

module onrq_cell #(
  parameter int ENTRY_BITS = 32
) (
  input  logic                   clk,
  input  onrq_pkg::cell_ctrl_t   ctrl,
  input  logic [ENTRY_BITS-1:0]  upper,
  input  logic [ENTRY_BITS-1:0]  wdata,
  output logic [ENTRY_BITS-1:0]  data
);

  always_ff @(posedge clk) begin
    if (ctrl.write) begin
      data <= wdata;
    end else if (ctrl.shift) begin
      data <= upper;
    end
  end

endmodule
